/* rtl/wspi_pkg.sv */
// Shared widths, types, register indexes and helpers for the wheel speed PI loop.
package wspi_pkg;

  localparam int MUL_W     = 29;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SPD_W     = 20;
  localparam int OUT_W     = 21;
  localparam int ERR_W     = 16;
  localparam int INT_W     = 22;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TICK_W    = 27;
  localparam int DIV_SH    = 27;
  localparam int SAT_W     = 28;

  typedef logic signed [MUL_W-1:0]  mul_opnd_t;
  typedef logic signed [PROD_W-1:0] mul_prod_t;
  typedef logic signed [SPD_W-1:0]  speed_t;
  typedef logic signed [OUT_W-1:0]  drive_t;
  typedef logic signed [ERR_W-1:0]  err_t;

  localparam logic [CFG_IDX_W-1:0] REG_RATIO_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CAP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_CAP    = 3'd7;

  localparam logic [15:0] RST_RATIO     = 16'd24359;
  localparam logic [14:0] RST_TARGET    = 15'd4000;
  localparam logic [15:0] RST_GAIN_P    = 16'd2908;
  localparam logic [15:0] RST_GAIN_I    = 16'd0;
  localparam logic [14:0] RST_SLEW      = 15'd200;
  localparam logic [14:0] RST_SPEED_CAP = 15'd20000;
  localparam logic [14:0] RST_ERROR_CAP = 15'd1600;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // integral ceiling: 50 with 16 fractional bits
  localparam logic [INT_W-1:0] INTEG_MAX = 22'd3276800;

  localparam logic signed [SAT_W-1:0] SAT_HI = 28'sd1048575;
  localparam logic signed [SAT_W-1:0] SAT_LO = -28'sd1048576;

  function automatic drive_t sat_out(input logic signed [SAT_W-1:0] x);
    drive_t r;
    if (x > SAT_HI) begin
      r = SAT_HI[OUT_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[OUT_W-1:0];
    end else begin
      r = x[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/wspi_mul.sv */
// Shared signed multiplier with a registered product.
module wspi_mul (
  input  logic                clk,
  input  wspi_pkg::mul_opnd_t mul_a,
  input  wspi_pkg::mul_opnd_t mul_b,
  output wspi_pkg::mul_prod_t prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

/* rtl/wheel_speed_pi_loop.sv */
// Top level of the wheel speed PI loop: sequencer, state and configuration registers.

// A sample command (command 0) turns the two encoder counts into a slew-limited speed,
// a capped error, a clamped integral and a new PI output; a tick command (command 1)
// interpolates the previous PI output toward the latest one by step_index/SMOOTH_STEPS.
// Every command gives one result: the smoothed drive, the filtered speed and the last
// error. All products go one after another through a single registered multiplier;
// the division by SMOOTH_STEPS is a reciprocal multiply and a correction on that same
// multiplier. The input side stalls from the transfer until the result is loaded into
// the output register, so a new item is taken only once the last one is through; a
// result that waits there holds the next item only at its final step.
module wheel_speed_pi_loop #(
  parameter int SMOOTH_STEPS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write,
  input  logic [wspi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wspi_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [15:0]                  in_left_count,
  input  logic signed [15:0]                  in_right_count,
  input  logic                                in_stop_flag,
  input  logic                                in_speed_flag,
  input  logic [4:0]                          in_step_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wspi_pkg::OUT_W-1:0]   out_drive_out,
  output logic signed [wspi_pkg::SPD_W-1:0]   out_filtered_speed,
  output logic signed [wspi_pkg::SPD_W-1:0]   out_speed_error
);

  localparam int MW = wspi_pkg::MUL_W;
  localparam int TW = wspi_pkg::TICK_W;
  localparam longint RECIP = (longint'(1) << wspi_pkg::DIV_SH) / SMOOTH_STEPS;
  localparam wspi_pkg::mul_opnd_t RECIP_OP = MW'(RECIP);
  localparam wspi_pkg::mul_opnd_t STEPS_OP = MW'(SMOOTH_STEPS);
  localparam logic [TW:0] STEPS_REM = (TW+1)'(SMOOTH_STEPS);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_LMUL = 5'd1;
  localparam logic [4:0] ST_RMUL = 5'd2;
  localparam logic [4:0] ST_AVG  = 5'd3;
  localparam logic [4:0] ST_SLEW = 5'd4;
  localparam logic [4:0] ST_ERR  = 5'd5;
  localparam logic [4:0] ST_IMUL = 5'd6;
  localparam logic [4:0] ST_INT  = 5'd7;
  localparam logic [4:0] ST_PI   = 5'd8;
  localparam logic [4:0] ST_TDIF = 5'd9;
  localparam logic [4:0] ST_TMUL = 5'd10;
  localparam logic [4:0] ST_TABS = 5'd11;
  localparam logic [4:0] ST_TRCP = 5'd12;
  localparam logic [4:0] ST_TQ   = 5'd13;
  localparam logic [4:0] ST_TQD  = 5'd14;
  localparam logic [4:0] ST_TFIX = 5'd15;
  localparam logic [4:0] ST_TSUM = 5'd16;
  localparam logic [4:0] ST_OUT  = 5'd17;

  logic [4:0] state_r, state_nxt;

  // configuration
  logic [15:0] ratio_left_r, ratio_right_r, gain_p_r, gain_i_r;
  logic [14:0] target_r, slew_r, cap_spd_r, cap_err_r;

  // captured input item
  logic signed [15:0] left_r, right_r;
  logic               clear_r;
  logic [4:0]         step_r;

  // loop state and scratch
  wspi_pkg::speed_t   ls_r, avg_r, filt_r;
  wspi_pkg::err_t     err_r;
  logic [wspi_pkg::INT_W-1:0] integ_r;
  wspi_pkg::drive_t   prev_r, latest_r, smooth_r;
  logic signed [21:0] dif_r;
  logic               neg_r;
  logic [TW-1:0]      mag_r, q_r;

  // result register
  logic               out_valid_r;
  wspi_pkg::drive_t   out_drive_r;
  wspi_pkg::speed_t   out_filt_r, out_err_r;

  wspi_pkg::mul_opnd_t mul_a, mul_b;
  wspi_pkg::mul_prod_t prod;

  logic signed [16:0] lc;
  logic signed [21:0] spd_raw, spd_cap, spd_sel;
  wspi_pkg::speed_t   spd_c;
  logic signed [20:0] avg_sum, slew_diff, slew21, err21, ecap21;
  logic signed [34:0] acc;
  logic signed [37:0] pi_sum;
  logic signed [TW-1:0] tick_v;
  logic [TW:0]        rem;
  logic signed [wspi_pkg::SAT_W-1:0] tick_q, tick_sum;
  logic               in_acc, out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_drive_out      = out_drive_r;
  assign out_filtered_speed = out_filt_r;
  assign out_speed_error    = out_err_r;

  wspi_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  // datapath arithmetic
  always_comb begin
    lc      = -$signed({left_r[15], left_r});
    spd_raw = prod[33:12];
    spd_cap = $signed({7'b0, cap_spd_r});
    spd_sel = (spd_raw > spd_cap) ? spd_cap : spd_raw;
    spd_c   = spd_sel[wspi_pkg::SPD_W-1:0];
    avg_sum = {ls_r[19], ls_r} + {spd_c[19], spd_c};
    slew_diff = {avg_r[19], avg_r} - {filt_r[19], filt_r};
    slew21  = $signed({6'b0, slew_r});
    err21   = $signed({6'b0, target_r}) - {filt_r[19], filt_r};
    ecap21  = $signed({6'b0, cap_err_r});
    acc     = $signed({13'b0, integ_r}) + prod[34:0];
    pi_sum  = $signed({prod[33:0], 4'b0}) + $signed({16'b0, integ_r});
    tick_v  = prod[TW-1:0];
    rem     = {1'b0, mag_r} - prod[TW:0];
    tick_q  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    tick_sum = tick_q + {{(wspi_pkg::SAT_W-wspi_pkg::OUT_W){prev_r[20]}}, prev_r};
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_LMUL: begin
        mul_a = {{(MW-17){lc[16]}}, lc};
        mul_b = {{(MW-16){1'b0}}, ratio_left_r};
      end
      ST_RMUL: begin
        mul_a = {{(MW-16){right_r[15]}}, right_r};
        mul_b = {{(MW-16){1'b0}}, ratio_right_r};
      end
      ST_IMUL: begin
        mul_a = {{(MW-16){err_r[15]}}, err_r};
        mul_b = {{(MW-16){1'b0}}, gain_i_r};
      end
      ST_INT: begin
        mul_a = {{(MW-16){err_r[15]}}, err_r};
        mul_b = {{(MW-16){1'b0}}, gain_p_r};
      end
      ST_TMUL: begin
        mul_a = {{(MW-22){dif_r[21]}}, dif_r};
        mul_b = {{(MW-5){1'b0}}, step_r};
      end
      ST_TRCP: begin
        mul_a = {{(MW-TW){1'b0}}, mag_r};
        mul_b = RECIP_OP;
      end
      ST_TQD: begin
        mul_a = {{(MW-TW){1'b0}}, q_r};
        mul_b = STEPS_OP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = (in_command == wspi_pkg::CMD_TICK) ? ST_TDIF : ST_LMUL;
      end
      ST_LMUL: state_nxt = ST_RMUL;
      ST_RMUL: state_nxt = ST_AVG;
      ST_AVG:  state_nxt = ST_SLEW;
      ST_SLEW: state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_IMUL;
      ST_IMUL: state_nxt = ST_INT;
      ST_INT:  state_nxt = ST_PI;
      ST_PI:   state_nxt = ST_OUT;
      ST_TDIF: state_nxt = ST_TMUL;
      ST_TMUL: state_nxt = ST_TABS;
      ST_TABS: state_nxt = ST_TRCP;
      ST_TRCP: state_nxt = ST_TQ;
      ST_TQ:   state_nxt = ST_TQD;
      ST_TQD:  state_nxt = ST_TFIX;
      ST_TFIX: state_nxt = ST_TSUM;
      ST_TSUM: state_nxt = ST_OUT;
      ST_OUT:  if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ratio_left_r  <= wspi_pkg::RST_RATIO;
      ratio_right_r <= wspi_pkg::RST_RATIO;
      target_r      <= wspi_pkg::RST_TARGET;
      gain_p_r      <= wspi_pkg::RST_GAIN_P;
      gain_i_r      <= wspi_pkg::RST_GAIN_I;
      slew_r        <= wspi_pkg::RST_SLEW;
      cap_spd_r     <= wspi_pkg::RST_SPEED_CAP;
      cap_err_r     <= wspi_pkg::RST_ERROR_CAP;
      filt_r        <= '0;
      err_r         <= '0;
      integ_r       <= '0;
      prev_r        <= '0;
      latest_r      <= '0;
      smooth_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_write) begin
        unique case (cfg_index)
          wspi_pkg::REG_RATIO_LEFT:   ratio_left_r  <= cfg_data;
          wspi_pkg::REG_RATIO_RIGHT:  ratio_right_r <= cfg_data;
          wspi_pkg::REG_TARGET_SPEED: target_r      <= cfg_data[14:0];
          wspi_pkg::REG_GAIN_P:       gain_p_r      <= cfg_data;
          wspi_pkg::REG_GAIN_I:       gain_i_r      <= cfg_data;
          wspi_pkg::REG_SLEW_LIMIT:   slew_r        <= cfg_data[14:0];
          wspi_pkg::REG_SPEED_CAP:    cap_spd_r     <= cfg_data[14:0];
          wspi_pkg::REG_ERROR_CAP:    cap_err_r     <= cfg_data[14:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_SLEW: begin
          // move toward the average by at most the slew limit
          if (slew_diff > slew21) begin
            filt_r <= filt_r + $signed({5'b0, slew_r});
          end else if (slew_diff < -slew21) begin
            filt_r <= filt_r - $signed({5'b0, slew_r});
          end else begin
            filt_r <= avg_r;
          end
        end
        ST_ERR: begin
          err_r <= (err21 > ecap21) ? ecap21[15:0] : err21[15:0];
        end
        ST_INT: begin
          if (clear_r || acc < 0) begin
            integ_r <= '0;
          end else if (acc > $signed({13'b0, wspi_pkg::INTEG_MAX})) begin
            integ_r <= wspi_pkg::INTEG_MAX;
          end else begin
            integ_r <= acc[wspi_pkg::INT_W-1:0];
          end
        end
        ST_PI: begin
          prev_r   <= latest_r;
          latest_r <= wspi_pkg::sat_out({{6{pi_sum[37]}}, pi_sum[37:16]});
        end
        ST_TSUM: begin
          smooth_r <= wspi_pkg::sat_out(tick_sum);
        end
        default: ;
      endcase

      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r  <= in_left_count;
      right_r <= in_right_count;
      clear_r <= in_stop_flag | in_speed_flag;
      step_r  <= in_step_index;
    end

    case (state_r)
      ST_RMUL: ls_r  <= spd_c;
      ST_AVG:  avg_r <= avg_sum[20:1];
      ST_TDIF: dif_r <= {latest_r[20], latest_r} - {prev_r[20], prev_r};
      ST_TABS: begin
        neg_r <= tick_v[TW-1];
        mag_r <= tick_v[TW-1] ? TW'(-tick_v) : TW'(tick_v);
      end
      ST_TQ:   q_r <= prod[wspi_pkg::DIV_SH +: TW];
      ST_TFIX: begin
        // estimate may fall one short of the true quotient
        if (rem >= STEPS_REM) begin
          q_r <= q_r + TW'(1);
        end
      end
      default: ;
    endcase

    if (state_r == ST_OUT && out_free) begin
      out_drive_r <= smooth_r;
      out_filt_r  <= filt_r;
      out_err_r   <= {{(wspi_pkg::SPD_W-wspi_pkg::ERR_W){err_r[15]}}, err_r};
    end
  end

endmodule
